// File: src/bitset_character_distance_unit_defines.svh
// assertion macros for the bitset character distance unit
`ifndef BITSET_CHARACTER_DISTANCE_UNIT_DEFINES_SVH
`define BITSET_CHARACTER_DISTANCE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg
// shared widths, codes and state type of the bitset character distance unit
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int STATE_BITS = 32;
    localparam int SCORE_W    = 6;
    localparam int MAX_CHARS  = 4096;
    localparam int CNT_W      = 13;
    localparam int DSUM_W     = 18;
    localparam int SSUM_W     = 23;
    localparam int SQ_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int TOTAL_W    = 13;
    localparam int DIST_W     = 34;
    localparam int STATUS_W   = 2;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 36;
    localparam int DVD_W      = 68;
    localparam int QUO_W      = 64;
    localparam int DIVS_W     = 13;
    localparam int DIV_STEPS  = 68;
    localparam int DIV_CNT_W  = 7;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = 6;
    localparam int SQRT_REM_W = 34;

    typedef logic [2:0]            metric_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    localparam metric_t METRIC_HAMMING    = 3'd0;
    localparam metric_t METRIC_MANHATTAN  = 3'd1;
    localparam metric_t METRIC_COMPARABLE = 3'd2;
    localparam metric_t METRIC_EUCLIDEAN  = 3'd3;
    localparam metric_t METRIC_MAXIMUM    = 3'd4;

    localparam status_t STATUS_VALID    = 2'd0;
    localparam status_t STATUS_NO_CMP   = 2'd1;
    localparam status_t STATUS_ZERO_DIV = 2'd2;

    localparam cfg_idx_t CFG_METRIC    = 2'd0;
    localparam cfg_idx_t CFG_TRANSLATE = 2'd1;
    localparam cfg_idx_t CFG_TOTAL     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCORE,
        ST_FINAL,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_SQRT,
        ST_EMIT
    } bcd_state_t;

endpackage

// File: src/bcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_in_if / bcd_out_if
// valid/ready channels for character words and distance words
// ----------------------------------------------------------------------------
interface bcd_in_if;
    import bcd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATE_BITS-1:0] state_a;
    logic [STATE_BITS-1:0] state_b;
    logic                  missing_a;
    logic                  missing_b;
    logic                  ordered;
    logic                  last;

    modport source (output valid, state_a, state_b, missing_a, missing_b, ordered, last,
                    input ready);
    modport sink   (input valid, state_a, state_b, missing_a, missing_b, ordered, last,
                    output ready);
endinterface

interface bcd_out_if;
    import bcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    status_t           status;

    modport source (output valid, distance, status, input ready);
    modport sink   (input valid, distance, status, output ready);
endinterface

// File: src/bcd_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_score
// per-character score: overlap test or shift-by-one search of the larger set
// ----------------------------------------------------------------------------
module bcd_score (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bcd_pkg::STATE_BITS-1:0] a,
    input  logic [bcd_pkg::STATE_BITS-1:0] b,
    input  logic                           ordered,
    output logic                           done,
    output logic [bcd_pkg::SCORE_W-1:0]    score
);
    import bcd_pkg::*;

    logic                  busy_reg;
    logic                  unord_reg;
    logic [STATE_BITS-1:0] big_reg;
    logic [STATE_BITS-1:0] small_reg;
    logic [SCORE_W-1:0]    k_reg;
    logic                  overlap;
    logic                  hit;

    assign overlap = |(big_reg & small_reg);
    assign hit     = unord_reg || overlap || (k_reg == SCORE_W'(STATE_BITS));
    assign done    = busy_reg && hit;
    assign score   = unord_reg ? SCORE_W'(!overlap) : k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            unord_reg <= !ordered;
            k_reg     <= '0;
            if (!ordered || (a > b))
            begin
                big_reg   <= a;
                small_reg <= b;
            end
            else
            begin
                big_reg   <= b;
                small_reg <= a;
            end
        end
        else if (busy_reg && !hit)
        begin
            big_reg <= big_reg >> 1;
            k_reg   <= k_reg + SCORE_W'(1);
        end
    end

endmodule

// File: src/bcd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_divider
// restoring divider, one quotient bit per cycle, low quotient bits kept
// ----------------------------------------------------------------------------
module bcd_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bcd_pkg::DVD_W-1:0]  dividend,
    input  logic [bcd_pkg::DIVS_W-1:0] divisor,
    output logic                       done,
    output logic [bcd_pkg::QUO_W-1:0]  quotient
);
    import bcd_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DIVS_W-1:0]    dvs_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIVS_W:0]      rem_sh;
    logic [DIVS_W:0]      diff;
    logic                 qbit;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign qbit     = (rem_sh >= {1'b0, dvs_reg});
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= qbit ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

endmodule

// File: src/bcd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_sqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module bcd_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bcd_pkg::QUO_W-1:0]   radicand,
    output logic                        done,
    output logic [bcd_pkg::ROOT_W-1:0]  root
);
    import bcd_pkg::*;

    logic                  busy_reg;
    logic [SQRT_CNT_W:0]   cnt_reg;
    logic [QUO_W-1:0]      rad_reg;
    logic [SQRT_REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQRT_REM_W+1:0] rem_sh;
    logic [SQRT_REM_W+1:0] trial;
    logic                  take;

    assign rem_sh = {rem_reg, rad_reg[QUO_W-1:QUO_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);
    assign done   = busy_reg && (cnt_reg == '0);
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= (SQRT_CNT_W+1)'(SQRT_STEPS);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - (SQRT_CNT_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? SQRT_REM_W'(rem_sh - trial) : rem_sh[SQRT_REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

endmodule

// File: src/bitset_character_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitset_character_distance_unit
// scores character pairs, accumulates per row pair, emits one distance word
// ----------------------------------------------------------------------------
// channel   dir  word
// in_ch     in   state_a, state_b, missing_a, missing_b, ordered, last
// out_ch    out  distance (34b, 16 fraction bits), status
// cfg       in   cfg_we, cfg_index, cfg_data (metric, translate, total_chars)
//
// one word at a time: a skipped word is not scored, an unordered word gets an
// overlap test, and an ordered word gets a shift-by-one search
// a last word then runs the bit-serial divider for hamming, and the multiply,
// the divider and then the 32-step root for euclidean
// the result sits in an output register; the next word is taken meanwhile
// reset clears the sequencer, accumulators and configuration at once
// ----------------------------------------------------------------------------
module bitset_character_distance_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    bcd_in_if.sink                        in_ch,
    bcd_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [bcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bcd_pkg::*;

    bcd_state_t          state_reg, state_next;
    metric_t             metric_reg;
    logic                translate_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DSUM_W-1:0]   dsum_reg, dsum_next;
    logic [SSUM_W-1:0]   ssum_reg, ssum_next;
    logic [SCORE_W-1:0]  max_reg, max_next;
    logic                last_reg;
    logic [DIST_W-1:0]   res_dist_reg, res_dist_next;
    status_t             res_status_reg, res_status_next;
    logic [PROD_W-1:0]   prod_reg;
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   out_dist_reg;
    status_t             out_status_reg;

    logic                accept;
    logic                skip;
    logic                load_out;
    logic                is_euclid;
    logic                score_start, score_done;
    logic [SCORE_W-1:0]  score;
    logic [SQ_W-1:0]     score_sq;
    logic                div_start, div_done;
    logic [DVD_W-1:0]    div_dividend;
    logic [DIVS_W-1:0]   div_divisor;
    logic [QUO_W-1:0]    quotient;
    logic                sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]   root;

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign accept          = in_ch.valid && in_ch.ready;
    assign skip            = in_ch.missing_a || in_ch.missing_b
                             || (count_reg >= CNT_W'(MAX_CHARS));
    assign score_start     = accept && !skip;
    assign is_euclid       = (metric_reg == METRIC_EUCLIDEAN);
    assign score_sq        = SQ_W'(score) * SQ_W'(score);

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.distance = out_dist_reg;
    assign out_ch.status   = out_status_reg;

    assign div_dividend = is_euclid ? {prod_reg, 32'b0}
                                    : DVD_W'({dsum_reg, {FRAC_BITS{1'b0}}});
    assign div_divisor  = (!is_euclid && translate_reg) ? (count_reg - CNT_W'(1))
                                                        : count_reg;

    bcd_score u_score (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (score_start),
        .a       (in_ch.state_a),
        .b       (in_ch.state_b),
        .ordered (in_ch.ordered),
        .done    (score_done),
        .score   (score)
    );

    bcd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    bcd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (quotient),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dsum_next       = dsum_reg;
        ssum_next       = ssum_reg;
        max_next        = max_reg;
        res_dist_next   = res_dist_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        load_out        = 1'b0;
        div_start       = 1'b0;
        sqrt_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!skip)
                    begin
                        state_next = ST_SCORE;
                    end
                    else if (in_ch.last)
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_SCORE:
            begin
                if (score_done)
                begin
                    count_next = count_reg + CNT_W'(1);
                    dsum_next  = dsum_reg + DSUM_W'(score);
                    ssum_next  = ssum_reg + SSUM_W'(score_sq);
                    if (score > max_reg)
                    begin
                        max_next = score;
                    end
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                res_dist_next   = '0;
                res_status_next = STATUS_VALID;
                state_next      = ST_EMIT;
                if (count_reg == '0)
                begin
                    res_status_next = STATUS_NO_CMP;
                end
                else
                begin
                    unique case (metric_reg)
                        METRIC_HAMMING:
                        begin
                            if (translate_reg && (count_reg == CNT_W'(1)))
                            begin
                                res_status_next = STATUS_ZERO_DIV;
                            end
                            else
                            begin
                                state_next = ST_DSTART;
                            end
                        end
                        METRIC_MANHATTAN:
                        begin
                            res_dist_next = {dsum_reg, {FRAC_BITS{1'b0}}};
                        end
                        METRIC_COMPARABLE:
                        begin
                            res_dist_next = DIST_W'({count_reg, {FRAC_BITS{1'b0}}});
                        end
                        METRIC_EUCLIDEAN:
                        begin
                            state_next = ST_MUL;
                        end
                        METRIC_MAXIMUM:
                        begin
                            res_dist_next = DIST_W'({max_reg, {FRAC_BITS{1'b0}}});
                        end
                        default:
                        begin
                            res_dist_next = '0;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (is_euclid)
                    begin
                        sqrt_start = 1'b1;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        res_dist_next = quotient[DIST_W-1:0];
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    res_dist_next = DIST_W'(root);
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    dsum_next      = '0;
                    ssum_next      = '0;
                    max_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dsum_reg      <= '0;
            ssum_reg      <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dsum_reg      <= dsum_next;
            ssum_reg      <= ssum_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg    <= METRIC_HAMMING;
            translate_reg <= 1'b0;
            total_reg     <= TOTAL_W'(MAX_CHARS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_METRIC:    metric_reg    <= metric_t'(cfg_data[2:0]);
                CFG_TRANSLATE: translate_reg <= cfg_data[0];
                CFG_TOTAL:     total_reg     <= cfg_data[TOTAL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= in_ch.last;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(ssum_reg) * PROD_W'(total_reg);
        end
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            out_dist_reg   <= res_dist_reg;
            out_status_reg <= res_status_reg;
        end
    end

endmodule

// File: src/bcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_checker
// port-level checks on the bitset character distance unit
// ----------------------------------------------------------------------------
`include "bitset_character_distance_unit_defines.svh"

module bcd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          in_last,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bcd_pkg::DIST_W-1:0]    out_distance,
    input  logic [bcd_pkg::STATUS_W-1:0]  out_status
);
    import bcd_pkg::*;

    `BCD_ASSERT_NOW(a_status_code, out_valid,
        (out_status == STATUS_VALID) || (out_status == STATUS_NO_CMP)
        || (out_status == STATUS_ZERO_DIV), "bad status code")

    `BCD_ASSERT_NOW(a_error_zero, out_valid && (out_status != STATUS_VALID),
        out_distance == '0, "nonzero distance with error status")

    `BCD_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_last,
        !in_ready, "ready right after a last word")

    `BCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_distance) && $stable(out_status), "stalled word changed")

endmodule

bind bitset_character_distance_unit bcd_checker u_bcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_last      (in_ch.last),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_distance (out_ch.distance),
    .out_status   (out_ch.status)
);

// File: dv/tb_bitset_character_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitset_character_distance_unit
// drives random and corner character words through the distance unit under
// several metric settings and idle patterns, and checks every distance word
// against a behavioral score and accumulate model
// ----------------------------------------------------------------------------
module tb_bitset_character_distance_unit;
    import bcd_pkg::*;

    typedef struct {
        logic [DIST_W-1:0] distance;
        status_t           status;
    } dist_word_t;

    class distance_scoreboard;
        metric_t      metric;
        bit           translate;
        bit [12:0]    total_chars;
        longint unsigned cnt, dsum, ssum, dmax;
        dist_word_t   pending[$];
        int           errors;

        function new();
            metric = METRIC_HAMMING;
            translate = 0;
            total_chars = 13'd4096;
            cnt = 0; dsum = 0; ssum = 0; dmax = 0;
            errors = 0;
        endfunction

        function longint unsigned shift_score(bit [31:0] a, bit [31:0] b, bit ord);
            bit [31:0] big, lil;
            if (!ord)
                return ((a & b) == 0) ? 1 : 0;
            big = (a > b) ? a : b;
            lil = (a > b) ? b : a;
            for (int k = 0; k < STATE_BITS; k++)
                if (((big >> k) & lil) != 0)
                    return k;
            return STATE_BITS;
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned r, bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > v)
                bt >>= 2;
            while (bt != 0)
            begin
                if (v >= r + bt)
                begin
                    v -= r + bt;
                    r = (r >> 1) + bt;
                end
                else
                    r >>= 1;
                bt >>= 2;
            end
            return r;
        endfunction

        function void note_char(bit [31:0] a, bit [31:0] b, bit ma, bit mb, bit ord, bit lst);
            longint unsigned d, exp_dist, num, q, r;
            dist_word_t w;
            status_t st;
            if (!(ma || mb) && cnt < MAX_CHARS)
            begin
                d = shift_score(a, b, ord);
                cnt++;
                dsum += d;
                ssum += d * d;
                if (d > dmax)
                    dmax = d;
            end
            if (!lst)
                return;
            exp_dist = 0;
            st = STATUS_VALID;
            if (cnt == 0)
                st = STATUS_NO_CMP;
            else
            begin
                case (metric)
                    METRIC_HAMMING:
                    begin
                        if (translate)
                        begin
                            if (cnt == 1)
                                st = STATUS_ZERO_DIV;
                            else
                                exp_dist = (dsum << 16) / (cnt - 1);
                        end
                        else
                            exp_dist = (dsum << 16) / cnt;
                    end
                    METRIC_MANHATTAN: exp_dist = dsum << 16;
                    METRIC_COMPARABLE: exp_dist = cnt << 16;
                    METRIC_EUCLIDEAN:
                    begin
                        num = ssum * total_chars;
                        q = num / cnt;
                        r = num % cnt;
                        exp_dist = int_root((q << 32) + ((r << 32) / cnt));
                    end
                    METRIC_MAXIMUM: exp_dist = dmax << 16;
                    default: exp_dist = 0;
                endcase
            end
            w.distance = exp_dist[DIST_W-1:0];
            w.status = st;
            pending.push_back(w);
            cnt = 0; dsum = 0; ssum = 0; dmax = 0;
        endfunction

        function void check_word(logic [DIST_W-1:0] got_dist, status_t st);
            dist_word_t w;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected distance word %h status %0d", got_dist, st);
                return;
            end
            w = pending.pop_front();
            if (got_dist !== w.distance || st !== w.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp dist %h status %0d, got dist %h status %0d",
                             w.distance, w.status, got_dist, st);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    bcd_in_if in_ch();
    bcd_out_if out_ch();

    bitset_character_distance_unit dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    distance_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;
    longint cycles = 0;

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.state_a = 0;
        in_ch.state_b = 0;
        in_ch.missing_a = 0;
        in_ch.missing_b = 0;
        in_ch.ordered = 0;
        in_ch.last = 0;
        out_ch.ready = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.distance, out_ch.status);
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic write_reg(cfg_idx_t idx, int unsigned val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_METRIC)
            sb.metric = val[2:0];
        else if (idx == CFG_TRANSLATE)
            sb.translate = val[0];
        else
            sb.total_chars = val[12:0];
        @(posedge clk);
    endtask

    task automatic send_char(bit [31:0] a, bit [31:0] b, bit ma, bit mb, bit ord, bit lst);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.state_a <= a;
        in_ch.state_b <= b;
        in_ch.missing_a <= ma;
        in_ch.missing_b <= mb;
        in_ch.ordered <= ord;
        in_ch.last <= lst;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_char(a, b, ma, mb, ord, lst);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic bit [31:0] rand_set();
        case ($urandom_range(5))
            0: return 32'd1 << $urandom_range(31);
            1: return 0;
            2: return 32'hffffffff;
            3: return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_row(int len);
        for (int i = 0; i < len; i++)
            send_char(rand_set(), rand_set(), ($urandom_range(9) == 0),
                      ($urandom_range(9) == 0), $urandom_range(1), i == len - 1);
    endtask

    initial
    begin
        int metrics[9];
        metrics = '{0, 1, 2, 3, 4, 3, 0, 5, 7};
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // corner words under default settings
        send_char(32'h0, 32'h0, 0, 0, 1, 0);
        send_char(32'h80000000, 32'h1, 0, 0, 1, 0);
        send_char(32'hffffffff, 32'hffffffff, 0, 0, 0, 0);
        send_char(32'haaaaaaaa, 32'h55555555, 0, 0, 0, 0);
        send_char(32'h1, 32'h0, 0, 0, 1, 0);
        send_char(32'h5, 32'h5, 1, 0, 0, 0);
        send_char(32'h5, 32'h5, 0, 1, 1, 1);
        send_char(32'h5, 32'h5, 1, 1, 0, 1);
        drain();
        write_reg(CFG_TRANSLATE, 1);
        send_char(32'h2, 32'h1, 0, 0, 1, 1);
        send_char(32'h2, 32'h1, 0, 0, 1, 0);
        send_char(32'hf0, 32'h1, 0, 0, 1, 1);
        drain();
        write_reg(CFG_TRANSLATE, 0);
        write_reg(CFG_METRIC, METRIC_EUCLIDEAN);
        write_reg(CFG_TOTAL, 0);
        send_char(32'h8, 32'h1, 0, 0, 1, 1);
        drain();
        write_reg(CFG_TOTAL, 1);
        send_char(32'h8, 32'h1, 0, 0, 1, 1);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            write_reg(CFG_METRIC, metrics[ph]);
            write_reg(CFG_TRANSLATE, $urandom_range(1));
            write_reg(CFG_TOTAL, (ph == 3) ? 4096 : (ph == 5) ? 8191 : $urandom_range(1, 4096));
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 78; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 78; end
                default: begin send_idle = 13; recv_stall = 13; end
            endcase
            for (int r = 0; r < 20; r++)
                random_row($urandom_range(1, 16));
            drain();
        end
        recv_stall = 0;
        drain();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: bitset_character_distance_unit.f
+incdir+src
src/bcd_pkg.sv
src/bcd_if.sv
src/bcd_score.sv
src/bcd_divider.sv
src/bcd_sqrt.sv
src/bitset_character_distance_unit.sv
src/bcd_checker.sv
dv/tb_bitset_character_distance_unit.sv
